### rtl/msh_pkg.sv
// Shared types, codes and constants for the masked sample histogram.
`timescale 1ns / 1ps

package msh_pkg;

   // Default sizes of the table and its fields
   localparam int DEF_TABLE_ENTRIES = 256;
   localparam int DEF_KEY_BITS      = 64;
   localparam int DEF_COUNT_BITS    = 32;

   // Hash: h = 8 ^ (key + seed + 513), all modulo 2^64
   localparam logic [63:0] HASH_SEED = 64'h0000_0000_9e37_79b9;
   localparam logic [63:0] HASH_BIAS = 64'd513;
   localparam logic [63:0] HASH_ADD  = HASH_SEED + HASH_BIAS;
   localparam logic [63:0] HASH_XOR  = 64'd8;

   // Command codes
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_COUNTED    = 3'd0;
   localparam logic [2:0] ST_INSERTED   = 3'd1;
   localparam logic [2:0] ST_DROPPED    = 3'd2;
   localparam logic [2:0] ST_READ_VALID = 3'd3;
   localparam logic [2:0] ST_READ_EMPTY = 3'd4;
   localparam logic [2:0] ST_CLEARED    = 3'd5;

   // Input transaction
   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] sample;
      logic [7:0]  slot_index;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] entry_key;
      logic [31:0] entry_count;
      logic [7:0]  entry_slot;
      logic [63:0] best_key;
      logic [31:0] best_count;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic hash_step;
      logic rd_home;
      logic rd_next;
      logic rd_slot;
      logic commit_add;
      logic emit_drop;
      logic emit_read;
      logic emit_clear;
      logic sweep_write;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic hash_ready;
      logic slot_empty;
      logic slot_match;
      logic probe_last;
      logic sweep_last;
      logic out_free;
   } dp_stat_type;

endpackage

### rtl/msh_ctrl.sv
// Controller state machine of the masked sample histogram.
`timescale 1ns / 1ps

module msh_ctrl
   import msh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_command,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      SWEEP,
      IDLE,
      HASH,
      PROBE_EV,
      DROP,
      READ_RD,
      READ_EV,
      CLEAR,
      CLEAR_RSP
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != IDLE);
      unique case (state_ff)
         SWEEP: begin
            cmd.sweep_write = 1'b1;
            if (stat.sweep_last) state_in = IDLE;
         end
         IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               unique case (req_command)
                  CMD_ADD:   state_in = HASH;
                  CMD_READ:  state_in = READ_RD;
                  CMD_CLEAR: state_in = CLEAR;
                  default:   state_in = IDLE;
               endcase
            end
         end
         HASH: begin
            if (stat.hash_ready) begin
               cmd.rd_home = 1'b1;
               state_in    = PROBE_EV;
            end else begin
               cmd.hash_step = 1'b1;
            end
         end
         PROBE_EV: begin
            if (stat.slot_empty || stat.slot_match) begin
               if (stat.out_free) begin
                  cmd.commit_add = 1'b1;
                  state_in       = IDLE;
               end
            end else if (stat.probe_last) begin
               state_in = DROP;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         DROP: begin
            if (stat.out_free) begin
               cmd.emit_drop = 1'b1;
               state_in      = IDLE;
            end
         end
         READ_RD: begin
            cmd.rd_slot = 1'b1;
            state_in    = READ_EV;
         end
         READ_EV: begin
            if (stat.out_free) begin
               cmd.emit_read = 1'b1;
               state_in      = IDLE;
            end
         end
         CLEAR: begin
            cmd.sweep_write = 1'b1;
            if (stat.sweep_last) state_in = CLEAR_RSP;
         end
         CLEAR_RSP: begin
            if (stat.out_free) begin
               cmd.emit_clear = 1'b1;
               state_in       = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/msh_dpath.sv
// Datapath of the masked sample histogram: mask, hash, slot memory, best tracking, output.
`timescale 1ns / 1ps

module msh_dpath
   import msh_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int KEY_BITS      = DEF_KEY_BITS,
   parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
   localparam int WORD_W  = 1 + KEY_BITS + COUNT_BITS;
   localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

   // Configuration and item registers
   logic [KEY_BITS-1:0]   mask_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [7:0]            idx_ff;
   logic [SLOT_W-1:0]     pos_ff;
   logic [SLOT_W-1:0]     probe_ff;
   logic [SLOT_W-1:0]     sweep_ff;
   logic [KEY_BITS-1:0]   top_key_ff;
   logic [COUNT_BITS-1:0] top_count_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   // Slot memory: {valid, key, count}
   logic [WORD_W-1:0]     slot_mem_ff [TABLE_ENTRIES];
   logic [WORD_W-1:0]     rd_word_ff;

   logic [KEY_BITS-1:0]   key_in;
   logic [63:0]           hash_in;
   logic [SLOT_W-1:0]     home;
   logic                  hash_ready;
   logic [SLOT_W-1:0]     pos_next;
   logic                  rd_en;
   logic [SLOT_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   logic [WORD_W-1:0]     wr_data;
   logic                  rd_valid;
   logic [KEY_BITS-1:0]   rd_key;
   logic [COUNT_BITS-1:0] rd_count;
   logic [COUNT_BITS-1:0] new_count;
   logic                  top_take;
   logic                  idx_in_range;
   logic                  out_free;
   rsp_type               rsp_in;

   // Masked key and hash of the incoming sample
   assign key_in  = KEY_BITS'(req_data.sample) & mask_ff;
   assign hash_in = HASH_XOR ^ (64'(key_in) + HASH_ADD);

   // Home slot: low hash bits, or a byte-serial reciprocal remainder for other table sizes
   generate
      if (IS_POW2) begin : g_home_mask
         logic [SLOT_W-1:0] home_ff;

         always_ff @(posedge clock) begin
            if (cmd.load_req) home_ff <= hash_in[SLOT_W-1:0];
         end

         assign home       = home_ff;
         assign hash_ready = 1'b1;
      end else begin : g_home_rem
         localparam int DIG_W = SLOT_W + 8;
         localparam int Q_SH  = DIG_W + SLOT_W;
         localparam int RCP_W = SLOT_W + 9;
         localparam int PRD_W = DIG_W + RCP_W;
         // Scaled reciprocal of the table size, exact for any digit below 2^DIG_W
         localparam logic [RCP_W-1:0] RECIP =
            RCP_W'(((64'd1 << Q_SH) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));

         logic [63:0]       hash_sh_ff;
         logic [SLOT_W-1:0] rem_ff;
         logic [7:0]        quot_ff;
         logic              phase_ff;
         logic [2:0]        byte_cnt_ff;
         logic              ready_ff;
         logic [DIG_W-1:0]  digit;
         logic [PRD_W-1:0]  prod;

         assign digit = {rem_ff, hash_sh_ff[63:56]};
         assign prod  = PRD_W'(digit) * PRD_W'(RECIP);

         // Hash bytes MSB first, each in two phases: quotient, then remainder
         always_ff @(posedge clock) begin
            if (cmd.load_req) begin
               hash_sh_ff <= hash_in;
               rem_ff     <= '0;
            end else if (cmd.hash_step) begin
               if (!phase_ff) begin
                  quot_ff <= prod[Q_SH +: 8];
               end else begin
                  rem_ff     <= SLOT_W'(digit - DIG_W'(quot_ff) * DIG_W'(TABLE_ENTRIES));
                  hash_sh_ff <= {hash_sh_ff[55:0], 8'd0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               phase_ff    <= 1'b0;
               byte_cnt_ff <= '0;
               ready_ff    <= 1'b0;
            end else if (cmd.load_req) begin
               phase_ff    <= 1'b0;
               byte_cnt_ff <= '0;
               ready_ff    <= 1'b0;
            end else if (cmd.hash_step) begin
               phase_ff <= !phase_ff;
               if (phase_ff) begin
                  byte_cnt_ff <= byte_cnt_ff + 3'd1;
                  if (byte_cnt_ff == 3'd7) ready_ff <= 1'b1;
               end
            end
         end

         assign home       = rem_ff;
         assign hash_ready = ready_ff;
      end
   endgenerate

   // Read data fields
   assign rd_valid = rd_word_ff[WORD_W-1];
   assign rd_key   = rd_word_ff[COUNT_BITS +: KEY_BITS];
   assign rd_count = rd_word_ff[COUNT_BITS-1:0];

   assign pos_next     = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;
   assign idx_in_range = 32'(idx_ff) < 32'(TABLE_ENTRIES);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Saturating count update, or one for a fresh insert
   always_comb begin
      if (!rd_valid) begin
         new_count = COUNT_BITS'(1);
      end else if (rd_count == '1) begin
         new_count = rd_count;
      end else begin
         new_count = rd_count + 1'b1;
      end
   end

   assign top_take = new_count > top_count_ff;

   // Memory port selection
   always_comb begin
      rd_en = cmd.rd_home || cmd.rd_next || cmd.rd_slot;
      if (cmd.rd_home) begin
         rd_addr = home;
      end else if (cmd.rd_next) begin
         rd_addr = pos_next;
      end else begin
         rd_addr = SLOT_W'(idx_ff);
      end
      wr_en = cmd.sweep_write || cmd.commit_add;
      if (cmd.sweep_write) begin
         wr_addr = sweep_ff;
         wr_data = '0;
      end else begin
         wr_addr = pos_ff;
         wr_data = {1'b1, key_ff, new_count};
      end
   end

   // Slot memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) slot_mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_word_ff <= slot_mem_ff[rd_addr];
   end

   // Item payload and probe position
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         key_ff <= key_in;
         idx_ff <= req_data.slot_index;
      end
      if (cmd.rd_home) begin
         pos_ff   <= home;
         probe_ff <= '0;
      end else if (cmd.rd_next) begin
         pos_ff   <= pos_next;
         probe_ff <= probe_ff + 1'b1;
      end
   end

   // Control registers: mask, sweep pointer, best entry, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '1;
         sweep_ff     <= '0;
         top_key_ff   <= '0;
         top_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) mask_ff <= KEY_BITS'(csr_wr_data);
         if (cmd.sweep_write) sweep_ff <= (sweep_ff == LAST_SLOT) ? '0 : sweep_ff + 1'b1;
         if (cmd.emit_clear) begin
            top_key_ff   <= '0;
            top_count_ff <= '0;
         end else if (cmd.commit_add && top_take) begin
            top_key_ff   <= key_ff;
            top_count_ff <= new_count;
         end
         if (cmd.commit_add || cmd.emit_drop || cmd.emit_read || cmd.emit_clear) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result assembly
   always_comb begin
      rsp_in            = '0;
      rsp_in.best_key   = 64'(top_key_ff);
      rsp_in.best_count = 32'(top_count_ff);
      if (cmd.commit_add) begin
         rsp_in.status      = rd_valid ? ST_COUNTED : ST_INSERTED;
         rsp_in.entry_key   = 64'(key_ff);
         rsp_in.entry_count = 32'(new_count);
         rsp_in.entry_slot  = 8'(pos_ff);
         if (top_take) begin
            rsp_in.best_key   = 64'(key_ff);
            rsp_in.best_count = 32'(new_count);
         end
      end else if (cmd.emit_drop) begin
         rsp_in.status    = ST_DROPPED;
         rsp_in.entry_key = 64'(key_ff);
      end else if (cmd.emit_read) begin
         rsp_in.entry_slot = idx_ff;
         if (idx_in_range && rd_valid) begin
            rsp_in.status      = ST_READ_VALID;
            rsp_in.entry_key   = 64'(rd_key);
            rsp_in.entry_count = 32'(rd_count);
         end else begin
            rsp_in.status = ST_READ_EMPTY;
         end
      end else begin
         rsp_in.status     = ST_CLEARED;
         rsp_in.best_key   = '0;
         rsp_in.best_count = '0;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (cmd.commit_add || cmd.emit_drop || cmd.emit_read || cmd.emit_clear) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status to the controller
   assign stat.hash_ready = hash_ready;
   assign stat.slot_empty = !rd_valid;
   assign stat.slot_match = rd_valid && (rd_key == key_ff);
   assign stat.probe_last = probe_ff == LAST_SLOT;
   assign stat.sweep_last = sweep_ff == LAST_SLOT;
   assign stat.out_free   = out_free;

endmodule

### rtl/masked_sample_histogram.sv
// Masked sample histogram: hashed, linearly probed count table with best-entry tracking.
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one command per transaction:
//   add sample, read slot or clear table. Command code 3 is taken and ignored.
//   rsp channel (rsp_valid/rsp_stall/rsp_data) returns one result per add, read or clear.
//   csr_wr_en/csr_wr_data: user writes key_mask only while block is idle (not enforced).
// Flow, from accept to result valid:
//   add: HASH, then PROBE_EV, which reads the next slot for each probe past the home
//   slot; for a table size that is not a power of two, HASH first works out the home
//   slot as a reciprocal-multiply remainder, each hash byte in a quotient and a remainder phase.
//   read: READ_RD, then READ_EV. clear: a one-slot-per-cycle sweep, then CLEAR_RSP.
//   Items are worked one at a time: the slot memory has one read and one write port,
//   so the next transaction is taken only once the result is loaded.
// Reset: the mask returns to all ones, best key and count to zero, and a clearing pass
//   empties every slot; req_stall is high until it ends.
// Stall: a result waits in the output register while rsp_stall is high. The next
//   command is still accepted and worked, and holds in its final state until the
//   output register frees up.
`timescale 1ns / 1ps

module masked_sample_histogram
   import msh_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int KEY_BITS      = DEF_KEY_BITS,
   parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Controller
   msh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   // Datapath
   msh_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEY_BITS      (KEY_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // Reset starts the clearing pass, so no transaction is taken right after it
   a_reset_sweep: assert property (@(posedge clock) reset |=> req_stall)
      else $error("transaction accepted during clearing pass");

   // A real command keeps the input stalled while it is worked
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       (req_data.command == CMD_ADD || req_data.command == CMD_READ ||
        req_data.command == CMD_CLEAR)) |=> req_stall)
      else $error("input not stalled after accepting a command");

   // The touched entry never counts above the best entry
   a_best_covers_entry: assert property (@(posedge clock) disable iff (reset)
      (COUNT_BITS <= 32 && rsp_valid &&
       (rsp_data.status == ST_COUNTED || rsp_data.status == ST_INSERTED))
      |-> rsp_data.entry_count <= rsp_data.best_count)
      else $error("entry count above best count");

   // A clear result reports an empty best entry
   a_clear_resets_best: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_CLEARED)
      |-> (rsp_data.best_count == 32'd0 && rsp_data.best_key == 64'd0))
      else $error("best entry not cleared");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the masked sample histogram: directed and random command streams.
`timescale 1ns / 1ps

module tb_top;
   import msh_pkg::*;

   localparam int          SLOTS         = DEF_TABLE_ENTRIES;
   localparam logic [1:0]  CMD_NONE      = 2'd3;           // unused code, block ignores it
   localparam logic [63:0] GOLDEN        = 64'h0000_0000_9e37_79b9;
   localparam logic [63:0] HASH_OFFSET   = 64'd513;
   localparam logic [63:0] HASH_FLIP     = 64'd8;
   localparam int          SETTLE_CYCLES = 300;            // longer than a full probe or a clear
   localparam int          HOLD_CYCLES   = 400;
   localparam int          PRINT_LIMIT   = 50;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   req_type     req_data    = '0;
   logic        rsp_stall   = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic [63:0] csr_wr_data = '0;
   logic        req_stall;
   logic        rsp_valid;
   rsp_type     rsp_data;

   masked_sample_histogram u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the count table, the best entry and the key mask
   bit          tbl_used  [SLOTS];
   logic [63:0] tbl_key   [SLOTS];
   logic [31:0] tbl_count [SLOTS];
   int          filled      = 0;
   logic [63:0] top_key_m   = '0;
   logic [31:0] top_count_m = '0;
   logic [63:0] mask_m      = '1;

   rsp_type     awaited_tallies [$];
   logic [63:0] seen_samples    [$];
   int          error_count  = 0;
   int          req_idle_pct = 20;
   int          rsp_idle_pct = 20;
   int          hold_left    = 0;

   function automatic logic [7:0] home_of(input logic [63:0] key);
      logic [63:0] h;
      h = HASH_FLIP ^ (key + GOLDEN + HASH_OFFSET);
      return h[7:0];
   endfunction

   // Key whose home slot is the given one
   function automatic logic [63:0] key_for_home(input logic [7:0] slot);
      return {56'd0, slot ^ HASH_FLIP[7:0]} - GOLDEN - HASH_OFFSET;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic req_type make_req(input logic [1:0] cmd, input logic [63:0] sample,
                                        input logic [7:0] idx);
      req_type r;
      r.command    = cmd;
      r.sample     = sample;
      r.slot_index = idx;
      return r;
   endfunction

   // Apply one command to the shadow table and work out its result
   task automatic histogram_apply(input req_type r, output bit has_rsp, output rsp_type res);
      logic [63:0] key;
      logic [7:0]  pos;
      bit          done;
      res     = '0;
      has_rsp = 1'b1;
      case (r.command)
         CMD_ADD: begin
            key             = r.sample & mask_m;
            pos             = home_of(key);
            done            = 1'b0;
            res.status      = ST_DROPPED;
            res.entry_key   = key;
            // linear probe with wrap until a match or a hole
            for (int n = 0; n < SLOTS && !done; n++) begin
               if (!tbl_used[pos]) begin
                  tbl_used[pos]  = 1'b1;
                  tbl_key[pos]   = key;
                  tbl_count[pos] = 32'd1;
                  filled++;
                  res.status = ST_INSERTED;
                  done       = 1'b1;
               end else if (tbl_key[pos] == key) begin
                  if (tbl_count[pos] != '1) tbl_count[pos]++;
                  res.status = ST_COUNTED;
                  done       = 1'b1;
               end else begin
                  pos++;
               end
            end
            if (done) begin
               res.entry_count = tbl_count[pos];
               res.entry_slot  = pos;
               // strict compare: on a tie the earlier key keeps the lead
               if (tbl_count[pos] > top_count_m) begin
                  top_count_m = tbl_count[pos];
                  top_key_m   = key;
               end
            end
         end
         CMD_READ: begin
            res.entry_slot = r.slot_index;
            if (tbl_used[r.slot_index]) begin
               res.status      = ST_READ_VALID;
               res.entry_key   = tbl_key[r.slot_index];
               res.entry_count = tbl_count[r.slot_index];
            end else begin
               res.status = ST_READ_EMPTY;
            end
         end
         CMD_CLEAR: begin
            foreach (tbl_used[i]) tbl_used[i] = 1'b0;
            filled      = 0;
            top_key_m   = '0;
            top_count_m = '0;
            res.status  = ST_CLEARED;
         end
         default: begin
            has_rsp = 1'b0;
         end
      endcase
      res.best_key   = top_key_m;
      res.best_count = top_count_m;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
   endtask

   // Offer one transaction, wait for it to be taken, record its expected result.
   // Entered and left at a falling edge with req_valid still high.
   task automatic send_req(input req_type item);
      int      gap;
      bit      has_rsp;
      rsp_type res;
      gap = pick_gap(req_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      histogram_apply(item, has_rsp, res);
      if (has_rsp) awaited_tallies.push_back(res);
      @(negedge clock);
   endtask

   task automatic add_sample(input logic [63:0] s);
      send_req(make_req(CMD_ADD, s, 8'($urandom_range(0, 255))));
   endtask

   task automatic read_slot(input logic [7:0] idx);
      send_req(make_req(CMD_READ, rand64(), idx));
   endtask

   task automatic clear_table();
      send_req(make_req(CMD_CLEAR, rand64(), 8'($urandom_range(0, 255))));
   endtask

   // Mask writes only once the block has drained and gone quiet
   task automatic set_key_mask(input logic [63:0] value);
      req_valid <= 1'b0;
      while (awaited_tallies.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mask_m = value;
   endtask

   // Counting, ties, probe wrap-around, ignored code and clear
   task automatic test_directed();
      logic [63:0] k;
      add_sample('0);
      add_sample('1);
      add_sample('0);
      add_sample('1);
      add_sample('1);
      read_slot(home_of('0));
      read_slot(home_of('1));
      read_slot(8'd0);
      read_slot(8'd255);
      send_req(make_req(CMD_NONE, rand64(), 8'($urandom_range(0, 255))));
      clear_table();
      // three keys sharing home slot 255 spill into 0 and 1
      k = key_for_home(8'hff);
      add_sample(k);
      add_sample(k + 64'd256);
      add_sample(k + 64'd512);
      add_sample(k + 64'd256);
      read_slot(8'd255);
      read_slot(8'd0);
      read_slot(8'd1);
      clear_table();
      read_slot(8'd0);
   endtask

   // Mask all zeros folds every sample onto key 0; a single top bit keeps only that bit
   task automatic test_mask_extremes();
      set_key_mask('0);
      repeat (3) add_sample(rand64());
      read_slot(home_of('0));
      set_key_mask(64'h8000_0000_0000_0000);
      add_sample('1);
      add_sample(rand64());
   endtask

   // Fill every slot, then hit the full table with new and known keys
   task automatic test_fill_to_capacity();
      logic [63:0] s;
      int          pick;
      set_key_mask('1);
      clear_table();
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      while (filled < SLOTS) begin
         pick = $urandom_range(0, 9);
         if (pick < 8 || seen_samples.size() == 0) begin
            s = rand64();
            seen_samples.push_back(s);
            add_sample(s);
         end else if (pick == 8) begin
            add_sample(seen_samples[$urandom_range(0, seen_samples.size() - 1)]);
         end else begin
            read_slot(8'($urandom_range(0, 255)));
         end
      end
      repeat (30) begin
         pick = $urandom_range(0, 2);
         if (pick == 0) add_sample(rand64());
         else if (pick == 1) add_sample(seen_samples[$urandom_range(0, seen_samples.size() - 1)]);
         else read_slot(8'($urandom_range(0, 255)));
      end
      clear_table();
   endtask

   // Mixed traffic under several masks and idling patterns
   task automatic test_random_masks();
      logic [63:0] m;
      logic [63:0] s;
      int          pick;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: m = rand64();
            1: begin
               m = '0;
               repeat (3) m[$urandom_range(0, 63)] = 1'b1;
            end
            2: m = '1;
            3: begin
               m = '0;
               repeat (8) m[$urandom_range(0, 63)] = 1'b1;
            end
            default: m = rand64() & rand64();
         endcase
         set_key_mask(m);
         req_idle_pct = (phase % 2 == 0) ? 0 : 35;
         rsp_idle_pct = (phase == 2) ? 0 : 15 + 10 * phase;
         repeat (80) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               if ($urandom_range(0, 1) == 0 || seen_samples.size() == 0) begin
                  s = rand64();
                  seen_samples.push_back(s);
               end else begin
                  s = seen_samples[$urandom_range(0, seen_samples.size() - 1)];
               end
               add_sample(s);
            end else if (pick < 90) begin
               if ($urandom_range(0, 1) == 0 && seen_samples.size() != 0)
                  read_slot(home_of(seen_samples[$urandom_range(0, seen_samples.size() - 1)]
                                    & mask_m));
               else
                  read_slot(8'($urandom_range(0, 255)));
            end else if (pick < 97) begin
               clear_table();
            end else begin
               send_req(make_req(CMD_NONE, rand64(), 8'($urandom_range(0, 255))));
            end
         end
      end
   endtask

   // Long receiver hold while the sender keeps offering, so the input backs up
   task automatic test_output_backpressure();
      req_valid <= 1'b0;
      while (awaited_tallies.size() != 0) @(negedge clock);
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      req_idle_pct = 0;
      repeat (10) begin
         if ($urandom_range(0, 2) == 0) read_slot(8'($urandom_range(0, 255)));
         else add_sample(rand64());
      end
      req_idle_pct = 20;
   endtask

   // Result-side stall: forced holds first, then random gaps
   initial begin
      int stall_left;
      int gap;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            gap = pick_gap(rsp_idle_pct);
            rsp_stall  <= (gap > 0);
            stall_left = (gap > 0) ? gap - 1 : 0;
         end
      end
   end

   // Compare every accepted result with the oldest expected one
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (awaited_tallies.size() == 0) begin
               report_mismatch("unexpected result, key", rsp_data.entry_key, '0);
            end else begin
               want = awaited_tallies.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.entry_key !== want.entry_key)
                  report_mismatch("entry_key", rsp_data.entry_key, want.entry_key);
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch("entry_count", 64'(rsp_data.entry_count),
                                  64'(want.entry_count));
               if (rsp_data.entry_slot !== want.entry_slot)
                  report_mismatch("entry_slot", 64'(rsp_data.entry_slot),
                                  64'(want.entry_slot));
               if (rsp_data.best_key !== want.best_key)
                  report_mismatch("best_key", rsp_data.best_key, want.best_key);
               if (rsp_data.best_count !== want.best_count)
                  report_mismatch("best_count", 64'(rsp_data.best_count),
                                  64'(want.best_count));
            end
         end
      end
   end

   // Sequence of tests
   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_mask_extremes();
      test_fill_to_capacity();
      test_output_backpressure();
      test_random_masks();
      // drain, then watch a while for stray results
      req_valid <= 1'b0;
      while (awaited_tallies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && awaited_tallies.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Run limit
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
